>>> rtl/uart_rf_pkg.sv
`default_nettype none
package uart_rf_pkg;
   // beat opcodes
   localparam logic [2:0] OP_READ   = 3'd0;
   localparam logic [2:0] OP_WRITE  = 3'd1;
   localparam logic [2:0] OP_RXCHAR = 3'd2;
   localparam logic [2:0] OP_TXRDY  = 3'd3;
   localparam logic [2:0] OP_MODEM  = 3'd4;
   // register offsets
   localparam logic [2:0] REG_DATA = 3'd0;
   localparam logic [2:0] REG_IER  = 3'd1;
   localparam logic [2:0] REG_IIR  = 3'd2;
   localparam logic [2:0] REG_LCR  = 3'd3;
   localparam logic [2:0] REG_MCR  = 3'd4;
   localparam logic [2:0] REG_LSR  = 3'd5;
   localparam logic [2:0] REG_MSR  = 3'd6;
   localparam logic [2:0] REG_SCR  = 3'd7;
   // interrupt identities
   localparam logic [3:0] IID_LINE  = 4'h6;
   localparam logic [3:0] IID_RX    = 4'h4;
   localparam logic [3:0] IID_THRE  = 4'h2;
   localparam logic [3:0] IID_MODEM = 4'h0;
   localparam logic [3:0] IID_NONE  = 4'h1;

   function automatic logic [4:0] trig_level(input logic [1:0] sel);
      case (sel)
         2'd0: trig_level = 5'd1;
         2'd1: trig_level = 5'd4;
         2'd2: trig_level = 5'd8;
         default: trig_level = 5'd14;
      endcase
   endfunction
endpackage
`default_nettype wire

>>> rtl/uart_rf_fifo_mem.sv
`default_nettype none
// simple dual port memory, registered read
module uart_rf_fifo_mem #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> rtl/uart_register_file_with_fifos_top.sv
`default_nettype none
// Channel | Dir | tdata fields (low bit up)
// req     | in  | opcode, reg_addr, write_data, rx_byte, rx_error, modem_in
// rsp     | out | read_data, tx_valid, tx_byte, irq, divisor, line_format, modem_out
// The FIFO memories are read as the beat is accepted (head entry prefetched);
// the result is then formed and the state written once the output register is
// free. A new beat is taken only after the previous one has finished.
// Reset is synchronous and clears all control state; FIFO contents are left.
// The result sits in an output register; a new beat is taken while it waits,
// but the next result waits for rsp_tready.
module uart_register_file_with_fifos_top
   import uart_rf_pkg::*;
#(
   parameter int FIFO_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // opcode[2:0] reg_addr[5:3] write_data[13:6] rx_byte[21:14] rx_error[24:22]
   // modem_in[28:25]
   input  wire logic [31:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // read_data[7:0] tx_valid[8] tx_byte[16:9] irq[17] divisor[33:18]
   // line_format[40:34] modem_out[44:41]
   output logic [47:0]      rsp_tdata
);
   localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CW = $clog2(FIFO_DEPTH + 1);
   localparam int TW = (CW > 5) ? CW : 5;
   localparam int MD = 1 << AW;

   // state
   logic [AW-1:0] rx_head_ff, tx_head_ff;
   logic [CW-1:0] rx_fill_ff, rx_bad_ff, tx_fill_ff;
   logic [3:0]    ier_ff, mcr_ff, sticky_ff;
   logic [7:0]    lcr_ff, dll_ff, dlm_ff, msr_ff, scr_ff;
   logic          fifo_on_ff, thre_ack_ff, busy_ff;
   logic [1:0]    trig_ff;
   logic          busy_stage_ff;
   logic [28:0]   beat_ff;
   logic          out_v_ff;
   logic [44:0]   out_ff;

   logic [8:0] rx_rd;
   logic [7:0] tx_rd;
   logic       rx_we, tx_we;
   logic [AW-1:0] rx_wa, tx_wa;
   logic [8:0] rx_wd;

   uart_rf_fifo_mem #(.WIDTH(9), .DEPTH(MD)) u_rx (
      .clock(clock), .wr_en(rx_we), .wr_addr(rx_wa), .wr_data(rx_wd),
      .rd_addr(rx_head_ff), .rd_data(rx_rd));
   uart_rf_fifo_mem #(.WIDTH(8), .DEPTH(MD)) u_tx (
      .clock(clock), .wr_en(tx_we), .wr_addr(tx_wa), .wr_data(beat_ff[13:6]),
      .rd_addr(tx_head_ff), .rd_data(tx_rd));

   // one beat in flight; output register must be free to finish
   assign req_tready = !busy_stage_ff;
   wire fin = busy_stage_ff && (!out_v_ff || rsp_tready);
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = {3'b0, out_ff};

   wire [2:0] op = beat_ff[2:0];
   wire [2:0] ad = beat_ff[5:3];
   wire [7:0] wd = beat_ff[13:6];
   wire [7:0] rb = beat_ff[21:14];
   wire [2:0] re = beat_ff[24:22];
   wire [3:0] mi = beat_ff[28:25];

   function automatic logic [3:0] iid(input logic [3:0] ie, input logic [3:0] st,
      input logic rxd, input logic txe, input logic ack, input logic [3:0] dm);
      if (ie[2] && st != 4'd0) iid = IID_LINE;
      else if (ie[0] && rxd) iid = IID_RX;
      else if (ie[1] && txe && !ack) iid = IID_THRE;
      else if (ie[3] && dm != 4'd0) iid = IID_MODEM;
      else iid = IID_NONE;
   endfunction

   // ring position h + n, wrapped at FIFO_DEPTH
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] h,
      input logic [CW-1:0] n);
      logic [CW:0] s;
      s = (CW+1)'(h) + (CW+1)'(n);
      if (s >= (CW+1)'(FIFO_DEPTH)) s = s - (CW+1)'(FIFO_DEPTH);
      wrap_add = AW'(s);
   endfunction

   logic [AW-1:0] rx_head_in, tx_head_in;
   logic [CW-1:0] rx_fill_in, rx_bad_in, tx_fill_in, cap, trig_cap;
   logic [3:0]    ier_in, mcr_in, sticky_in, id_now, id_new;
   logic [7:0]    lcr_in, dll_in, dlm_in, msr_in, scr_in, rd, txb;
   logic          fifo_on_in, thre_ack_in, busy_in, txv, dlab, rx_due_now, rx_due_new;
   logic [1:0]    trig_in;
   logic [3:0]    chg, dd;

   function automatic logic [CW-1:0] trc(input logic [1:0] s, input logic on,
      input logic [CW-1:0] c);
      logic [TW-1:0] t;
      t = TW'(trig_level(s));
      if (!on) trc = CW'(1);
      else if (t > TW'(c)) trc = c;
      else trc = CW'(t);
   endfunction

   always_comb begin
      rx_head_in = rx_head_ff; tx_head_in = tx_head_ff;
      rx_fill_in = rx_fill_ff; rx_bad_in = rx_bad_ff; tx_fill_in = tx_fill_ff;
      ier_in = ier_ff; mcr_in = mcr_ff; sticky_in = sticky_ff;
      lcr_in = lcr_ff; dll_in = dll_ff; dlm_in = dlm_ff; msr_in = msr_ff;
      scr_in = scr_ff; fifo_on_in = fifo_on_ff; thre_ack_in = thre_ack_ff;
      busy_in = busy_ff; trig_in = trig_ff;
      rd = 8'd0; txv = 1'b0; txb = 8'd0;
      rx_we = 1'b0; tx_we = 1'b0; rx_wd = {|re, rb};
      rx_wa = wrap_add(rx_head_ff, rx_fill_ff); tx_wa = wrap_add(tx_head_ff, tx_fill_ff);
      chg = 4'd0; dd = 4'd0;
      dlab = lcr_ff[7];
      cap = fifo_on_ff ? CW'(FIFO_DEPTH) : CW'(1);
      trig_cap = trc(trig_ff, fifo_on_ff, cap);
      rx_due_now = fifo_on_ff ? (rx_fill_ff >= trig_cap) : (rx_fill_ff != 0);
      id_now = iid(ier_ff, sticky_ff, rx_due_now, tx_fill_ff == 0, thre_ack_ff,
                   msr_ff[3:0]);
      case (op)
         OP_READ: begin
            case (ad)
               REG_DATA: begin
                  if (dlab) rd = dll_ff;
                  else if (rx_fill_ff != 0) begin
                     rd = rx_rd[7:0];
                     if (rx_rd[8] && rx_bad_ff != 0) rx_bad_in = rx_bad_ff - 1'b1;
                     rx_head_in = wrap_add(rx_head_ff, CW'(1));
                     rx_fill_in = rx_fill_ff - 1'b1;
                  end
               end
               REG_IER: rd = dlab ? dlm_ff : {4'd0, ier_ff};
               REG_IIR: begin
                  if (id_now == IID_THRE) thre_ack_in = 1'b1;
                  rd = {fifo_on_ff, fifo_on_ff, 2'b00, id_now};
               end
               REG_LCR: rd = lcr_ff;
               REG_MCR: rd = {4'd0, mcr_ff};
               REG_LSR: begin
                  rd = {fifo_on_ff && rx_bad_ff != 0, tx_fill_ff == 0 && !busy_ff,
                        tx_fill_ff == 0, sticky_ff, rx_fill_ff != 0};
                  sticky_in = 4'd0;
               end
               REG_MSR: begin
                  rd = msr_ff;
                  msr_in = {msr_ff[7:4], 4'd0};
               end
               default: rd = scr_ff;
            endcase
         end
         OP_WRITE: begin
            case (ad)
               REG_DATA: begin
                  if (dlab) dll_in = wd;
                  else begin
                     if (tx_fill_ff < cap) begin
                        tx_we = 1'b1;
                        tx_fill_in = tx_fill_ff + 1'b1;
                     end
                     thre_ack_in = 1'b0;
                  end
               end
               REG_IER: begin
                  if (dlab) dlm_in = wd;
                  else begin
                     ier_in = wd[3:0];
                     thre_ack_in = 1'b0;
                  end
               end
               REG_IIR: begin
                  fifo_on_in = wd[0];
                  if ((fifo_on_ff != wd[0]) || (wd[0] && wd[1])) begin
                     rx_head_in = '0; rx_fill_in = '0; rx_bad_in = '0;
                  end
                  if ((fifo_on_ff != wd[0]) || (wd[0] && wd[2])) begin
                     tx_head_in = '0; tx_fill_in = '0; thre_ack_in = 1'b0;
                  end
                  if (wd[0]) trig_in = wd[7:6];
               end
               REG_LCR: lcr_in = wd;
               REG_MCR: mcr_in = wd[3:0];
               REG_SCR: scr_in = wd;
               default: ;
            endcase
         end
         OP_RXCHAR: begin
            sticky_in = sticky_ff | {re, 1'b0};
            if (rx_fill_ff < cap) begin
               rx_we = 1'b1;
               rx_fill_in = rx_fill_ff + 1'b1;
               if (re != 3'd0) rx_bad_in = rx_bad_ff + 1'b1;
            end else begin
               sticky_in[0] = 1'b1;
               if (!fifo_on_ff) begin
                  rx_we = 1'b1;
                  rx_wa = rx_head_ff;
                  rx_bad_in = rx_bad_ff;
                  if (rx_rd[8] && rx_bad_ff != 0) rx_bad_in = rx_bad_ff - 1'b1;
                  if (re != 3'd0) rx_bad_in = rx_bad_in + 1'b1;
               end
            end
         end
         OP_TXRDY: begin
            if (tx_fill_ff != 0) begin
               txb = tx_rd; txv = 1'b1; busy_in = 1'b1;
               tx_head_in = wrap_add(tx_head_ff, CW'(1));
               tx_fill_in = tx_fill_ff - 1'b1;
            end else busy_in = 1'b0;
         end
         OP_MODEM: begin
            chg = msr_ff[7:4] ^ mi;
            dd = msr_ff[3:0] | {chg[3], msr_ff[6] & ~mi[2], chg[1], chg[0]};
            msr_in = {mi, dd};
         end
         default: ;
      endcase
      rx_due_new = fifo_on_in ? (rx_fill_in >= trc(trig_in, fifo_on_in,
                   CW'(FIFO_DEPTH))) : (rx_fill_in != 0);
      id_new = iid(ier_in, sticky_in, rx_due_new, tx_fill_in == 0, thre_ack_in,
                   msr_in[3:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_head_ff <= '0; tx_head_ff <= '0; rx_fill_ff <= '0; rx_bad_ff <= '0;
         tx_fill_ff <= '0; ier_ff <= '0; mcr_ff <= '0; sticky_ff <= '0;
         lcr_ff <= '0; dll_ff <= '0; dlm_ff <= '0; msr_ff <= '0; scr_ff <= '0;
         fifo_on_ff <= 1'b0; thre_ack_ff <= 1'b0; busy_ff <= 1'b0; trig_ff <= '0;
         busy_stage_ff <= 1'b0; out_v_ff <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            busy_stage_ff <= 1'b1;
            beat_ff <= req_tdata[28:0];
         end
         // output register: load on finish, else free on handshake
         if (fin) out_v_ff <= 1'b1;
         else if (rsp_tready) out_v_ff <= 1'b0;
         if (fin) begin
            busy_stage_ff <= 1'b0;
            out_ff <= {mcr_in, lcr_in[6:0], dlm_in, dll_in,
                       (id_new != IID_NONE) && mcr_in[3], txb, txv, rd};
            rx_head_ff <= rx_head_in; tx_head_ff <= tx_head_in;
            rx_fill_ff <= rx_fill_in; rx_bad_ff <= rx_bad_in; tx_fill_ff <= tx_fill_in;
            ier_ff <= ier_in; mcr_ff <= mcr_in; sticky_ff <= sticky_in;
            lcr_ff <= lcr_in; dll_ff <= dll_in; dlm_ff <= dlm_in; msr_ff <= msr_in;
            scr_ff <= scr_in; fifo_on_ff <= fifo_on_in; thre_ack_ff <= thre_ack_in;
            busy_ff <= busy_in; trig_ff <= trig_in;
         end
      end
   end
endmodule
`default_nettype wire

>>> verif/tb_uart_register_file_with_fifos_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_uart_register_file_with_fifos_top;
   import uart_rf_pkg::*;

   localparam int DEPTH = 16;
   localparam int IDLE_LIMIT = 5000;

   // one request beat
   typedef struct packed {
      logic [3:0] modem_in;
      logic [2:0] rx_error;
      logic [7:0] rx_byte;
      logic [7:0] write_data;
      logic [2:0] reg_addr;
      logic [2:0] opcode;
   } req_beat_t;

   // one response beat
   typedef struct packed {
      logic [3:0]  modem_out;
      logic [6:0]  line_format;
      logic [15:0] divisor;
      logic        irq;
      logic [7:0]  tx_byte;
      logic        tx_valid;
      logic [7:0]  read_data;
   } rsp_beat_t;

   // predicts UART register-file behavior and checks responses in order
   class uart_scoreboard;
      logic [8:0] rx_mem[DEPTH];
      logic [7:0] tx_mem[DEPTH];
      int rx_head, rx_fill, rx_bad, tx_head, tx_fill;
      logic [3:0] ier, mcr;
      logic [7:0] lcr, dll, dlm, msr, scr;
      logic fifo_en, thre_ack, busy;
      logic [1:0] trig;
      logic [3:0] lerr;
      rsp_beat_t pending[$];
      int mismatches;

      function int cap();
         return fifo_en ? DEPTH : 1;
      endfunction

      function bit rx_ready();
         int t;
         if (!fifo_en) return rx_fill > 0;
         case (trig)
            2'd0: t = 1;
            2'd1: t = 4;
            2'd2: t = 8;
            default: t = 14;
         endcase
         if (t > cap()) t = cap();
         return rx_fill >= t;
      endfunction

      function logic [3:0] int_id();
         if (ier[2] && lerr != 0) return IID_LINE;
         if (ier[0] && rx_ready()) return IID_RX;
         if (ier[1] && tx_fill == 0 && !thre_ack) return IID_THRE;
         if (ier[3] && msr[3:0] != 0) return IID_MODEM;
         return IID_NONE;
      endfunction

      function logic [7:0] reg_read(logic [2:0] a);
         logic [8:0] e;
         logic [7:0] v;
         logic [3:0] id;
         v = 8'h00;
         case (a)
            REG_DATA: begin
               if (lcr[7]) return dll;
               if (rx_fill == 0) return 8'h00;
               e = rx_mem[rx_head];
               if (e[8] && rx_bad > 0) rx_bad--;
               rx_head = (rx_head + 1) % DEPTH;
               rx_fill--;
               return e[7:0];
            end
            REG_IER: return lcr[7] ? dlm : {4'h0, ier};
            REG_IIR: begin
               id = int_id();
               if (id == IID_THRE) thre_ack = 1;
               return {fifo_en ? 2'b11 : 2'b00, 2'b00, id};
            end
            REG_LCR: return lcr;
            REG_MCR: return {4'h0, mcr};
            REG_LSR: begin
               v[0] = rx_fill > 0;
               v[4:1] = lerr;
               v[5] = tx_fill == 0;
               v[6] = tx_fill == 0 && !busy;
               v[7] = fifo_en && rx_bad != 0;
               lerr = 0;
               return v;
            end
            REG_MSR: begin
               v = msr;
               msr[3:0] = 0;
               return v;
            end
            default: return scr;
         endcase
      endfunction

      function void reg_write(logic [2:0] a, logic [7:0] d);
         logic was;
         case (a)
            REG_DATA: begin
               if (lcr[7]) dll = d;
               else begin
                  if (tx_fill < cap()) begin
                     tx_mem[(tx_head + tx_fill) % DEPTH] = d;
                     tx_fill++;
                  end
                  thre_ack = 0;
               end
            end
            REG_IER: begin
               if (lcr[7]) dlm = d;
               else begin
                  ier = d[3:0];
                  thre_ack = 0;
               end
            end
            REG_IIR: begin
               was = fifo_en;
               fifo_en = d[0];
               if (was != fifo_en) begin
                  rx_head = 0; rx_fill = 0; rx_bad = 0;
                  tx_head = 0; tx_fill = 0; thre_ack = 0;
               end
               if (fifo_en) begin
                  if (d[1]) begin
                     rx_head = 0; rx_fill = 0; rx_bad = 0;
                  end
                  if (d[2]) begin
                     tx_head = 0; tx_fill = 0; thre_ack = 0;
                  end
                  trig = d[7:6];
               end
            end
            REG_LCR: lcr = d;
            REG_MCR: mcr = d[3:0];
            REG_SCR: scr = d;
            default: ;
         endcase
      endfunction

      function void char_arrive(logic [7:0] b, logic [2:0] err);
         logic [8:0] e;
         e = {err != 0, b};
         lerr |= {err, 1'b0};
         if (rx_fill < cap()) begin
            rx_mem[(rx_head + rx_fill) % DEPTH] = e;
            rx_fill++;
            if (err != 0) rx_bad++;
         end else begin
            lerr[0] = 1;
            if (!fifo_en) begin
               if (rx_mem[rx_head][8] && rx_bad > 0) rx_bad--;
               rx_mem[rx_head] = e;
               if (err != 0) rx_bad++;
            end
         end
      endfunction

      function void lines_change(logic [3:0] lines);
         logic [3:0] prev, d;
         prev = msr[7:4];
         d = msr[3:0];
         d[0] |= prev[0] ^ lines[0];
         d[1] |= prev[1] ^ lines[1];
         d[2] |= prev[2] & ~lines[2];
         d[3] |= prev[3] ^ lines[3];
         msr = {lines, d};
      endfunction

      function void note_request(req_beat_t r);
         rsp_beat_t x;
         x = '0;
         case (r.opcode)
            OP_READ: x.read_data = reg_read(r.reg_addr);
            OP_WRITE: reg_write(r.reg_addr, r.write_data);
            OP_RXCHAR: char_arrive(r.rx_byte, r.rx_error);
            OP_TXRDY: begin
               if (tx_fill > 0) begin
                  x.tx_byte = tx_mem[tx_head];
                  x.tx_valid = 1;
                  tx_head = (tx_head + 1) % DEPTH;
                  tx_fill--;
                  busy = 1;
               end else busy = 0;
            end
            OP_MODEM: lines_change(r.modem_in);
            default: ;
         endcase
         x.irq = int_id() != IID_NONE && mcr[3];
         x.divisor = {dlm, dll};
         x.line_format = lcr[6:0];
         x.modem_out = mcr;
         pending.push_back(x);
      endfunction

      function void check_response(rsp_beat_t got);
         rsp_beat_t want;
         if (pending.size() == 0) begin
            report_bad("unexpected beat", '0, got);
            return;
         end
         want = pending.pop_front();
         if (got.read_data != want.read_data || got.tx_valid != want.tx_valid ||
             got.tx_byte != want.tx_byte || got.irq != want.irq ||
             got.divisor != want.divisor || got.line_format != want.line_format ||
             got.modem_out != want.modem_out)
            report_bad("field mismatch", want, got);
      endfunction

      function void report_bad(string what, rsp_beat_t want, rsp_beat_t got);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%s: expected rd=%h txv=%b txb=%h irq=%b div=%h lf=%h mo=%h,",
               what, want.read_data, want.tx_valid, want.tx_byte, want.irq,
               want.divisor, want.line_format, want.modem_out);
            $display("   got rd=%h txv=%b txb=%h irq=%b div=%h lf=%h mo=%h",
               got.read_data, got.tx_valid, got.tx_byte, got.irq, got.divisor,
               got.line_format, got.modem_out);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [31:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [47:0] rsp_tdata;

   uart_scoreboard sb;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_cycles = 0;
   bit hung = 0;
   bit fifo_mode = 0;

   always #1 clock = ~clock;

   uart_register_file_with_fifos_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // response side: random backpressure, check accepted beats
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_beat_t'(rsp_tdata[44:0]));
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles <= 0;
      else if (!reset) stall_cycles <= stall_cycles + 1;
      if (stall_cycles > IDLE_LIMIT && !hung) begin
         hung = 1;
         $display("tb_uart_register_file_with_fifos_top failed");
         $finish;
      end
   end

   // valid stays high after a beat; the next call or drain decides
   task automatic send_beat(req_beat_t r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {3'b000, r};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic send_op(logic [2:0] op, logic [2:0] a, logic [7:0] wd,
                          logic [7:0] rb = 8'h00, logic [2:0] re = 3'd0,
                          logic [3:0] mi = 4'h0);
      req_beat_t r;
      r.opcode = op; r.reg_addr = a; r.write_data = wd;
      r.rx_byte = rb; r.rx_error = re; r.modem_in = mi;
      send_beat(r);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // mostly well-formed register traffic with random content
   task automatic random_beat();
      req_beat_t r;
      int pick;
      r = req_beat_t'(29'({$urandom, $urandom}));
      pick = $urandom_range(99);
      if (pick < 3) r.opcode = 3'($urandom_range(5, 7));
      else if (pick < 25) r.opcode = OP_READ;
      else if (pick < 45) r.opcode = OP_WRITE;
      else if (pick < 70) r.opcode = OP_RXCHAR;
      else if (pick < 88) r.opcode = OP_TXRDY;
      else r.opcode = OP_MODEM;
      if (r.opcode == OP_RXCHAR && $urandom_range(3) != 0) r.rx_error = 3'd0;
      if (r.opcode == OP_WRITE) begin
         // keep DLAB mostly clear and FIFO mode mostly steady
         if (r.reg_addr == REG_LCR && $urandom_range(3) != 0) r.write_data[7] = 1'b0;
         if (r.reg_addr == REG_IIR && $urandom_range(4) != 0) r.write_data[0] = fifo_mode;
         if (r.reg_addr == REG_IIR) fifo_mode = r.write_data[0];
      end
      if (r.opcode == OP_READ && r.reg_addr == REG_DATA && $urandom_range(1) == 0)
         r.reg_addr = REG_LSR;
      send_beat(r);
   endtask

   initial begin
      sb = new();
      sb.rx_head = 0; sb.rx_fill = 0; sb.rx_bad = 0; sb.tx_head = 0; sb.tx_fill = 0;
      sb.ier = 0; sb.mcr = 0; sb.lcr = 0; sb.dll = 0; sb.dlm = 0; sb.msr = 0;
      sb.scr = 0; sb.fifo_en = 0; sb.thre_ack = 0; sb.busy = 0; sb.trig = 0;
      sb.lerr = 0; sb.mismatches = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, every register, special cases
      send_op(OP_WRITE, REG_MCR, 8'hFF);
      send_op(OP_WRITE, REG_IER, 8'hFF);
      send_op(OP_READ, REG_IIR, 8'h00);
      send_op(OP_READ, REG_DATA, 8'h00);
      send_op(OP_WRITE, REG_LCR, 8'hFF);
      send_op(OP_WRITE, REG_DATA, 8'hFF);
      send_op(OP_WRITE, REG_IER, 8'hA5);
      send_op(OP_READ, REG_DATA, 8'h00);
      send_op(OP_READ, REG_IER, 8'h00);
      send_op(OP_WRITE, REG_LCR, 8'h00);
      send_op(OP_RXCHAR, 3'd0, 8'h00, 8'hFF, 3'd7);
      send_op(OP_RXCHAR, 3'd0, 8'h00, 8'h00, 3'd0);
      send_op(OP_READ, REG_LSR, 8'h00);
      send_op(OP_WRITE, REG_DATA, 8'h5A);
      send_op(OP_WRITE, REG_DATA, 8'hA5);
      send_op(OP_TXRDY, 3'd0, 8'h00);
      send_op(OP_TXRDY, 3'd0, 8'h00);
      send_op(OP_MODEM, 3'd0, 8'h00, 8'h00, 3'd0, 4'hF);
      send_op(OP_MODEM, 3'd0, 8'h00, 8'h00, 3'd0, 4'h0);
      send_op(OP_READ, REG_MSR, 8'h00);
      send_op(OP_WRITE, REG_SCR, 8'hFF);
      send_op(OP_READ, REG_SCR, 8'h00);
      send_op(OP_WRITE, REG_IIR, 8'hC7);
      send_op(OP_WRITE, REG_LSR, 8'hFF);
      send_op(3'd7, 3'd7, 8'hFF, 8'hFF, 3'd7, 4'hF);
      drain();

      // random phases with different idling
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 46 : 0;
         recv_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 22 : 0;
         for (int i = 0; i < 510; i++) begin
            random_beat();
            if (i == 250) drain();
         end
         drain();
      end

      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("tb_uart_register_file_with_fifos_top passed");
      else
         $display("tb_uart_register_file_with_fifos_top failed");
      $finish;
   end
endmodule
`default_nettype wire
